// File: design/scene_text_token_lexer_unit_defines.svh
// Assertion macros for the scene text token lexer checker.
`ifndef SCENE_TEXT_TOKEN_LEXER_UNIT_DEFINES_SVH
`define SCENE_TEXT_TOKEN_LEXER_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define STTL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define STTL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define STTL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sttl_pkg.sv
// Types, codes and byte classification for the scene text token lexer.
`default_nettype none
package sttl_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int POS_W           = 16;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUM     = 3'd2,
		MODE_STR     = 3'd3,
		MODE_ESC     = 3'd4,
		MODE_SLASH   = 3'd5,
		MODE_COMMENT = 3'd6
	} mode_t;

	localparam logic [1:0] CLASS_IGNORED = 2'd0;
	localparam logic [1:0] CLASS_START   = 2'd1;
	localparam logic [1:0] CLASS_CONT    = 2'd2;

	localparam logic [1:0] KIND_SYMBOL = 2'd0;
	localparam logic [1:0] KIND_IDENT  = 2'd1;
	localparam logic [1:0] KIND_NUM    = 2'd2;
	localparam logic [1:0] KIND_STR    = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_INVALID  = 3'd1;
	localparam logic [2:0] ERR_SLASH    = 3'd2;
	localparam logic [2:0] ERR_UNCLOSED = 3'd3;
	localparam logic [2:0] ERR_HELD     = 3'd4;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       file_start;
		logic       file_end;
	} src_word_t;

	typedef struct packed {
		logic [1:0]       byte_class;
		logic [1:0]       token_kind;
		logic [POS_W-1:0] line_number;
		logic [POS_W-1:0] column_number;
		logic [2:0]       error_code;
	} res_word_t;

	typedef struct packed {
		mode_t mode;
		logic  cr_pending;
		logic  error_held;
	} lex_ctl_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_symbol(input logic [7:0] c);
		return c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON || c == CH_COMMA
			|| c == CH_AT;
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return c == CH_UNDER || c == CH_DOLLAR || is_alpha(c);
	endfunction

	function automatic logic is_ident_cont(input logic [7:0] c);
		return c == CH_UNDER || is_alpha(c) || is_digit(c);
	endfunction

	function automatic logic is_num_start(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_DOT || is_digit(c);
	endfunction

	function automatic logic is_num_cont(input logic [7:0] c);
		return c == CH_DOT || is_digit(c);
	endfunction

endpackage
`default_nettype wire

// File: design/sttl_step.sv
// Per-word lexer step: mode update, position counting, error reporting.
`default_nettype none
module sttl_step #(
	parameter int LINE_BITS   = sttl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = sttl_pkg::COLUMN_BITS_DEF
) (
	input  sttl_pkg::src_word_t   src,
	input  sttl_pkg::lex_ctl_t    ctl,
	input  logic [LINE_BITS-1:0]  line,
	input  logic [COLUMN_BITS-1:0] col,
	output sttl_pkg::lex_ctl_t    ctl_nxt,
	output logic [LINE_BITS-1:0]  line_nxt,
	output logic [COLUMN_BITS-1:0] col_nxt,
	output sttl_pkg::res_word_t   res
);

	sttl_pkg::mode_t        mode_e;
	sttl_pkg::mode_t        mode_n;
	logic                   cr_e;
	logic                   held_e;
	logic [LINE_BITS-1:0]   line_e;
	logic [COLUMN_BITS-1:0] col_e;
	logic [7:0]             c;
	logic [1:0]             cls;
	logic [1:0]             kind;
	logic [2:0]             err;
	logic                   idle;
	logic                   brk;
	logic                   adv;
	logic                   cr_n;
	logic [sttl_pkg::POS_W-1:0] line_out;
	logic [sttl_pkg::POS_W-1:0] col_out;

	// file_start restarts from the reset state
	assign mode_e = src.file_start ? sttl_pkg::MODE_IDLE : ctl.mode;
	assign cr_e   = src.file_start ? 1'b0 : ctl.cr_pending;
	assign held_e = src.file_start ? 1'b0 : ctl.error_held;
	assign line_e = src.file_start ? '0 : line;
	assign col_e  = src.file_start ? '0 : col;
	assign c      = src.byte_in;

	always_comb begin
		cls    = sttl_pkg::CLASS_IGNORED;
		kind   = sttl_pkg::KIND_SYMBOL;
		err    = sttl_pkg::ERR_NONE;
		idle   = 1'b0;
		brk    = 1'b0;
		adv    = 1'b1;
		cr_n   = 1'b0;
		mode_n = mode_e;
		if (cr_e && c == sttl_pkg::CH_LF) begin
			adv = 1'b0;
		end else begin
			unique case (mode_e)
				sttl_pkg::MODE_ESC: begin
					cls    = sttl_pkg::CLASS_CONT;
					kind   = sttl_pkg::KIND_STR;
					mode_n = sttl_pkg::MODE_STR;
				end
				sttl_pkg::MODE_STR: begin
					if (c == sttl_pkg::CH_CR || c == sttl_pkg::CH_LF) begin
						err  = sttl_pkg::ERR_UNCLOSED;
						idle = 1'b1;
					end else begin
						cls  = sttl_pkg::CLASS_CONT;
						kind = sttl_pkg::KIND_STR;
						if (c == sttl_pkg::CH_QUOTE) begin
							mode_n = sttl_pkg::MODE_IDLE;
						end else if (c == sttl_pkg::CH_BSLASH) begin
							mode_n = sttl_pkg::MODE_ESC;
						end
					end
				end
				sttl_pkg::MODE_IDENT: begin
					if (sttl_pkg::is_ident_cont(c)) begin
						cls  = sttl_pkg::CLASS_CONT;
						kind = sttl_pkg::KIND_IDENT;
					end else begin
						idle = 1'b1;
					end
				end
				sttl_pkg::MODE_NUM: begin
					if (sttl_pkg::is_num_cont(c)) begin
						cls  = sttl_pkg::CLASS_CONT;
						kind = sttl_pkg::KIND_NUM;
					end else begin
						idle = 1'b1;
					end
				end
				sttl_pkg::MODE_SLASH: begin
					if (c == sttl_pkg::CH_SLASH) begin
						mode_n = sttl_pkg::MODE_COMMENT;
					end else begin
						err  = sttl_pkg::ERR_SLASH;
						idle = 1'b1;
					end
				end
				sttl_pkg::MODE_COMMENT: begin
					if (c == sttl_pkg::CH_CR || c == sttl_pkg::CH_LF) begin
						idle = 1'b1;
					end
				end
				default: begin
					idle = 1'b1;
				end
			endcase
			if (idle) begin
				mode_n = sttl_pkg::MODE_IDLE;
				if (c == sttl_pkg::CH_SP || c == sttl_pkg::CH_TAB) begin
					cls = sttl_pkg::CLASS_IGNORED;
				end else if (c == sttl_pkg::CH_CR) begin
					brk  = 1'b1;
					cr_n = 1'b1;
				end else if (c == sttl_pkg::CH_LF) begin
					brk = 1'b1;
				end else if (sttl_pkg::is_symbol(c)) begin
					cls  = sttl_pkg::CLASS_START;
					kind = sttl_pkg::KIND_SYMBOL;
				end else if (sttl_pkg::is_ident_start(c)) begin
					cls    = sttl_pkg::CLASS_START;
					kind   = sttl_pkg::KIND_IDENT;
					mode_n = sttl_pkg::MODE_IDENT;
				end else if (sttl_pkg::is_num_start(c)) begin
					cls    = sttl_pkg::CLASS_START;
					kind   = sttl_pkg::KIND_NUM;
					mode_n = sttl_pkg::MODE_NUM;
				end else if (c == sttl_pkg::CH_QUOTE) begin
					cls    = sttl_pkg::CLASS_START;
					kind   = sttl_pkg::KIND_STR;
					mode_n = sttl_pkg::MODE_STR;
				end else if (c == sttl_pkg::CH_SLASH) begin
					mode_n = sttl_pkg::MODE_SLASH;
				end else if (err == sttl_pkg::ERR_NONE) begin
					err = sttl_pkg::ERR_INVALID;
				end
			end
		end

		// end of file: report open string or pending slash, drop back to idle
		if (src.file_end) begin
			if (err == sttl_pkg::ERR_NONE
				&& (mode_n == sttl_pkg::MODE_STR || mode_n == sttl_pkg::MODE_ESC)) begin
				err = sttl_pkg::ERR_UNCLOSED;
			end
			if (err == sttl_pkg::ERR_NONE && mode_n == sttl_pkg::MODE_SLASH) begin
				err = sttl_pkg::ERR_SLASH;
			end
			mode_n = sttl_pkg::MODE_IDLE;
			cr_n   = 1'b0;
		end
	end

	always_comb begin
		line_nxt = line_e;
		col_nxt  = col_e;
		if (brk) begin
			line_nxt = (line_e == '1) ? line_e : line_e + 1'b1;
			col_nxt  = '0;
		end else if (adv) begin
			col_nxt = (col_e == '1) ? col_e : col_e + 1'b1;
		end
	end

	generate
		if (LINE_BITS > sttl_pkg::POS_W) begin : g_line_clamp
			assign line_out = (|line_e[LINE_BITS-1:sttl_pkg::POS_W]) ? '1
				: line_e[sttl_pkg::POS_W-1:0];
		end else begin : g_line_ext
			assign line_out = sttl_pkg::POS_W'(line_e);
		end
		if (COLUMN_BITS > sttl_pkg::POS_W) begin : g_col_clamp
			assign col_out = (|col_e[COLUMN_BITS-1:sttl_pkg::POS_W]) ? '1
				: col_e[sttl_pkg::POS_W-1:0];
		end else begin : g_col_ext
			assign col_out = sttl_pkg::POS_W'(col_e);
		end
	endgenerate

	assign ctl_nxt.mode       = mode_n;
	assign ctl_nxt.cr_pending = cr_n;
	assign ctl_nxt.error_held = held_e || (err != sttl_pkg::ERR_NONE);

	assign res.byte_class    = cls;
	assign res.token_kind    = kind;
	assign res.line_number   = line_out;
	assign res.column_number = col_out;
	assign res.error_code    = (err != sttl_pkg::ERR_NONE) ? err
		: (held_e ? sttl_pkg::ERR_HELD : sttl_pkg::ERR_NONE);

endmodule
`default_nettype wire

// File: design/scene_text_token_lexer_unit.sv
// Scene text token lexer: input register, lexer step, state and result register.
//
//  channel | signals                       | word type
//  --------+-------------------------------+---------------------
//  source  | src_valid src_ready src_data  | sttl_pkg::src_word_t
//  result  | res_valid res_ready res_data  | sttl_pkg::res_word_t
//
// One result word per source word, one word per cycle sustained while res_ready holds.
// Each word passes through the source register, then the result register.
// The lexer state advances when a word moves into the result register.
// A stalled result holds; one more word waits in the source register.
// arst_n clears valids, lexer mode, flags and position counters.
`default_nettype none
module scene_text_token_lexer_unit #(
	parameter int LINE_BITS   = sttl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = sttl_pkg::COLUMN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  sttl_pkg::src_word_t src_data,
	output logic                res_valid,
	input  logic                res_ready,
	output sttl_pkg::res_word_t res_data
);

	sttl_pkg::src_word_t    src_s1;
	logic                   vld_s1;
	sttl_pkg::lex_ctl_t     ctl_q;
	sttl_pkg::lex_ctl_t     ctl_nxt;
	logic [LINE_BITS-1:0]   line_q;
	logic [LINE_BITS-1:0]   line_nxt;
	logic [COLUMN_BITS-1:0] col_q;
	logic [COLUMN_BITS-1:0] col_nxt;
	sttl_pkg::res_word_t    res_nxt;
	sttl_pkg::res_word_t    res_s2;
	logic                   vld_s2;
	logic                   advance;

	assign advance   = vld_s1 && (!vld_s2 || res_ready);
	assign src_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (src_ready) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			src_s1 <= src_data;
		end
	end

	sttl_step #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_step (
		.src      (src_s1),
		.ctl      (ctl_q),
		.line     (line_q),
		.col      (col_q),
		.ctl_nxt  (ctl_nxt),
		.line_nxt (line_nxt),
		.col_nxt  (col_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode       <= sttl_pkg::MODE_IDLE;
			ctl_q.cr_pending <= 1'b0;
			ctl_q.error_held <= 1'b0;
			line_q           <= '0;
			col_q            <= '0;
		end else if (advance) begin
			ctl_q  <= ctl_nxt;
			line_q <= line_nxt;
			col_q  <= col_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (res_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid = vld_s2;
	assign res_data  = res_s2;

endmodule
`default_nettype wire

// File: design/sttl_chk.sv
// Port-level checker for the scene text token lexer, bound to the top level.
`default_nettype none
`include "scene_text_token_lexer_unit_defines.svh"
module sttl_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                src_valid,
	input wire logic                src_ready,
	input wire sttl_pkg::src_word_t src_data,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire sttl_pkg::res_word_t res_data
);

	logic src_seen;

	// source words are not consumed by the checker, only sampled
	assign src_seen = src_valid && src_ready && (src_data.file_start || !src_data.file_start);

	`STTL_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result word changed while stalled")
	`STTL_ASSERT_IMP(a_class_code, res_valid, res_data.byte_class == sttl_pkg::CLASS_IGNORED || res_data.byte_class == sttl_pkg::CLASS_START || res_data.byte_class == sttl_pkg::CLASS_CONT, "bad byte class")
	`STTL_ASSERT_IMP(a_ignored_kind, res_valid && res_data.byte_class == sttl_pkg::CLASS_IGNORED, res_data.token_kind == sttl_pkg::KIND_SYMBOL, "ignored byte with nonzero kind")
	`STTL_ASSERT_IMP(a_cont_err, res_valid && res_data.byte_class == sttl_pkg::CLASS_CONT, res_data.error_code != sttl_pkg::ERR_INVALID && res_data.error_code != sttl_pkg::ERR_SLASH, "continuation byte raised invalid or slash error")
	`STTL_ASSERT_NXT(a_no_empty_result, !res_valid && !src_seen, !res_valid || $past(src_ready), "result appeared with no source word pending")

endmodule

bind scene_text_token_lexer_unit sttl_chk u_sttl_chk (.*);
`default_nettype wire
